FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pag_pkg.sv
// ----------------------------------------------------------------------------
// pag_pkg
// Types and constants of the ORAM path address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pag_pkg;

  localparam int ADDR_W        = 40;
  localparam int LEAF_W        = 30;
  localparam int NODE_W        = 31;
  localparam int LEVEL_W       = 4;
  localparam int SLOT_W        = 2;
  localparam int BUCKET_W      = 17;
  localparam int BLOCK_W       = 13;
  localparam int SLOTS_W       = 3;
  localparam int ARITY_W       = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int MUL_W         = NODE_W + BUCKET_W;
  localparam int POW_W         = NODE_W + ARITY_W;
  localparam int OFF_W         = 15;
  localparam int MAX_ADDR_BITS = 64;

  localparam int DIV_W         = 32;
  localparam int DIV_RADIX_B   = 4;
  localparam int DIV_STEPS     = DIV_W / DIV_RADIX_B;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [NODE_W-1:0] INDEX_LIMIT = NODE_W'(1) << LEAF_W;

  localparam logic [ADDR_W-1:0]   RST_TREE_BASE   = '0;
  localparam logic [BUCKET_W-1:0] RST_BUCKET      = BUCKET_W'(256);
  localparam logic [BLOCK_W-1:0]  RST_BLOCK       = BLOCK_W'(64);
  localparam logic [SLOTS_W-1:0]  RST_SLOTS       = SLOTS_W'(4);
  localparam logic [ARITY_W-1:0]  RST_ARITY       = ARITY_W'(2);
  localparam logic [LEVEL_W-1:0]  RST_DEPTH       = LEVEL_W'(15);
  localparam logic [ADDR_W-1:0]   RST_HEADER_BASE = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TREE_BASE   = 3'd0,
    CFG_BUCKET      = 3'd1,
    CFG_BLOCK       = 3'd2,
    CFG_SLOTS       = 3'd3,
    CFG_ARITY       = 3'd4,
    CFG_DEPTH       = 3'd5,
    CFG_HEADER_BASE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              cmd;
    logic [LEAF_W-1:0] leaf;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [LEVEL_W-1:0] level;
    logic [SLOT_W-1:0]  slot;
    logic               last;
    logic               error;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   tree_base;
    logic [BUCKET_W-1:0] bucket_bytes;
    logic [BLOCK_W-1:0]  block_bytes;
    logic [SLOTS_W-1:0]  slots;
    logic [ARITY_W-1:0]  arity;
    logic [LEVEL_W-1:0]  depth;
    logic [ADDR_W-1:0]   header_base;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/oram_path_address_generator.sv
// ----------------------------------------------------------------------------
// oram_path_address_generator
// Emits the byte addresses of every block or header on a root-to-leaf path
// of an arity-ary ORAM tree.
// ----------------------------------------------------------------------------
// A request (start while busy is low) carries a leaf and a mode. busy stays
// high until the final result, flagged by last, appears; each result is
// valid for exactly one cycle with out_valid and must be taken then.
// An out-of-range leaf, an arity below two or arity^depth above 2^30 gives one
// error result. A valid request yields one address per level in header mode
// and one per slot in data mode: the node numbers are found leaf first by a
// shared divider producing four quotient bits per cycle (each level: node
// write, divider load, dividing steps), then each level passes through the
// node multiply and the base add before its addresses are emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module oram_path_address_generator import pag_pkg::*; #(
  parameter int MAX_LEVELS = 16,
  parameter int MAX_SLOTS  = 4,
  parameter int ADDR_BITS  = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 in_req,
  output logic                      out_valid,
  output res_t                      out_res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POW   = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_NODE  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  cfg_t cfg_eff;

  pag_cfg_regs #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_eff   (cfg_eff)
  );

  state_t               state_r, state_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [LEAF_W-1:0]    leaf_r, leaf_nxt;
  logic [NODE_W-1:0]    base_r, base_nxt;
  logic [NODE_W-1:0]    n_r, n_nxt;
  logic [LEVEL_W-1:0]   cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [MUL_W-1:0]     prod_r, prod_nxt;
  logic [ADDR_BITS-1:0] bkt_r, bkt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic [NODE_W-1:0]    nodes_r [MAX_LEVELS];

  logic                 node_we;
  logic                 div_start;
  logic                 div_done;
  logic [NODE_W-1:0]    div_quo;

  pag_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (cfg_eff.arity),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    logic [POW_W-1:0]         pow_prod;
    logic [BUCKET_W-1:0]      stride;
    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_BITS-1:0]     sum;
    logic [MAX_ADDR_BITS-1:0] wide;
    logic                     slot_last;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    leaf_nxt      = leaf_r;
    base_nxt      = base_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    prod_nxt      = prod_r;
    bkt_nxt       = bkt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    node_we       = 1'b0;
    div_start     = 1'b0;
    pow_prod  = POW_W'(base_r) * POW_W'(cfg_eff.arity);
    stride    = cmd_r ? BUCKET_W'(cfg_eff.block_bytes) : cfg_eff.bucket_bytes;
    base_addr = cmd_r ? cfg_eff.header_base : cfg_eff.tree_base;
    sum       = bkt_r + ADDR_BITS'(off_r);
    wide      = MAX_ADDR_BITS'(sum);
    slot_last = cmd_r || ({1'b0, slot_r} == cfg_eff.slots - 1'b1);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_req.cmd;
          leaf_nxt  = in_req.leaf;
          base_nxt  = NODE_W'(1);
          cnt_nxt   = '0;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        priority if (cfg_eff.arity < ARITY_W'(2)) begin
          state_nxt = S_IDLE;
        end else if (cnt_r == cfg_eff.depth) begin
          state_nxt = ({1'b0, leaf_r} >= base_r) ? S_IDLE : S_SETUP;
        end else if (pow_prod > POW_W'(INDEX_LIMIT)) begin
          state_nxt = S_IDLE;
        end else begin
          base_nxt = pow_prod[NODE_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (state_nxt == S_IDLE) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.address = '0;
          out_res_nxt.level   = '0;
          out_res_nxt.slot    = '0;
          out_res_nxt.last    = 1'b1;
          out_res_nxt.error   = 1'b1;
        end
      end
      S_SETUP: begin
        n_nxt     = {1'b0, leaf_r} + base_r;
        lvl_nxt   = cfg_eff.depth;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        node_we = 1'b1;
        if (lvl_r == '0) begin
          state_nxt = S_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          n_nxt     = div_quo;
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_MUL: begin
        prod_nxt  = MUL_W'(nodes_r[lvl_r[IDX_W-1:0]]) * MUL_W'(stride);
        slot_nxt  = '0;
        off_nxt   = '0;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        bkt_nxt   = ADDR_BITS'(base_addr) + ADDR_BITS'(prod_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt       = 1'b1;
        out_res_nxt.address = wide[ADDR_W-1:0];
        out_res_nxt.level   = lvl_r;
        out_res_nxt.slot    = slot_r;
        out_res_nxt.last    = slot_last && (lvl_r == cfg_eff.depth);
        out_res_nxt.error   = 1'b0;
        off_nxt             = off_r + OFF_W'(cfg_eff.block_bytes);
        slot_nxt            = slot_r + 1'b1;
        if (slot_last) begin
          if (lvl_r == cfg_eff.depth) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    leaf_r    <= leaf_nxt;
    base_r    <= base_nxt;
    n_r       <= n_nxt;
    cnt_r     <= cnt_nxt;
    lvl_r     <= lvl_nxt;
    slot_r    <= slot_nxt;
    off_r     <= off_nxt;
    prod_r    <= prod_nxt;
    bkt_r     <= bkt_nxt;
    out_res_r <= out_res_nxt;
    if (node_we) begin
      nodes_r[lvl_r[IDX_W-1:0]] <= n_r - 1'b1;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "assert_macros.svh"

  `PAG_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `PAG_ASSERT_IMP(a_error_single, out_valid && out_res.error,
                  out_res.last && (out_res.address == '0), "malformed error result")
  `PAG_ASSERT_IMP(a_mid_busy, out_valid && !out_res.last, busy, "idle before last result")
  `PAG_ASSERT_NXT(a_last_gap, out_valid && out_res.last, !out_valid, "result after last")

endmodule

`default_nettype wire

FILE: rtl/pag_cfg_regs.sv
// ----------------------------------------------------------------------------
// pag_cfg_regs
// Configuration register file with clamped effective values.
// ----------------------------------------------------------------------------
`default_nettype none

module pag_cfg_regs import pag_pkg::*; #(
  parameter int MAX_LEVELS = 16,
  parameter int MAX_SLOTS  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata,
  output cfg_t                      cfg_eff
);

  logic [ADDR_W-1:0]   tree_base_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [BLOCK_W-1:0]  block_r;
  logic [SLOTS_W-1:0]  slots_r;
  logic [ARITY_W-1:0]  arity_r;
  logic [LEVEL_W-1:0]  depth_r;
  logic [ADDR_W-1:0]   header_base_r;

  localparam logic [LEVEL_W-1:0] DEPTH_MAX = LEVEL_W'(MAX_LEVELS - 1);
  localparam logic [SLOTS_W-1:0] SLOTS_MAX = SLOTS_W'(MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_base_r   <= RST_TREE_BASE;
      bucket_r      <= RST_BUCKET;
      block_r       <= RST_BLOCK;
      slots_r       <= RST_SLOTS;
      arity_r       <= RST_ARITY;
      depth_r       <= RST_DEPTH;
      header_base_r <= RST_HEADER_BASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TREE_BASE:   tree_base_r   <= cfg_wdata;
        CFG_BUCKET:      bucket_r      <= cfg_wdata[BUCKET_W-1:0];
        CFG_BLOCK:       block_r       <= cfg_wdata[BLOCK_W-1:0];
        CFG_SLOTS:       slots_r       <= cfg_wdata[SLOTS_W-1:0];
        CFG_ARITY:       arity_r       <= cfg_wdata[ARITY_W-1:0];
        CFG_DEPTH:       depth_r       <= cfg_wdata[LEVEL_W-1:0];
        CFG_HEADER_BASE: header_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.tree_base    = tree_base_r;
    cfg_eff.bucket_bytes = bucket_r;
    cfg_eff.block_bytes  = block_r;
    cfg_eff.arity        = arity_r;
    cfg_eff.header_base  = header_base_r;
    cfg_eff.depth        = (depth_r > DEPTH_MAX) ? DEPTH_MAX : depth_r;
    priority if (slots_r == '0) begin
      cfg_eff.slots = SLOTS_W'(1);
    end else if (slots_r > SLOTS_MAX) begin
      cfg_eff.slots = SLOTS_MAX;
    end else begin
      cfg_eff.slots = slots_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pag_divider.sv
// ----------------------------------------------------------------------------
// pag_divider
// Iterative restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pag_divider import pag_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NODE_W-1:0]  dividend,
  input  wire logic [ARITY_W-1:0] divisor,
  output logic                    done,
  output logic [NODE_W-1:0]       quotient
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [ARITY_W-1:0]   rem_r, rem_nxt;
  logic [ARITY_W-1:0]   dvs_r, dvs_nxt;

  always_comb begin
    logic [ARITY_W:0]   trial;
    logic [ARITY_W-1:0] rem;
    logic [DIV_W-1:0]   quo;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem      = rem_r;
    quo      = quo_r;
    trial    = '0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = DIV_W'(dividend);
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      for (int k = 0; k < DIV_RADIX_B; k++) begin
        trial = {rem, quo[DIV_W-1]};
        if (trial >= {1'b0, dvs_r}) begin
          rem = ARITY_W'(trial - {1'b0, dvs_r});
          quo = {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem = trial[ARITY_W-1:0];
          quo = {quo[DIV_W-2:0], 1'b0};
        end
      end
      rem_nxt = rem;
      quo_nxt = quo;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[NODE_W-1:0];

endmodule

`default_nettype wire

FILE: test/oram_path_address_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oram_path_address_generator_tb
// Drives leaf requests in data and header mode through several register
// settings and compares every emitted address, level, slot, last and error
// flag with a predictor of the root-to-leaf path walk kept alongside.
// ----------------------------------------------------------------------------

module oram_path_address_generator_tb;
  import pag_pkg::*;

  localparam int                   LIMIT      = 600000;
  localparam int                   SETTLE     = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  req_t                 in_req    = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  res_t                 out_res;

  req_t  leaf_q[$];
  res_t  addr_q[$];
  cfg_t  shadow;
  logic  req_taken = 1'b0;
  int    gap_pct   = 0;
  int    errors    = 0;
  int    cycle_cnt = 0;

  oram_path_address_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] leaf_span(input logic [ARITY_W-1:0] ar,
                                            input logic [LEVEL_W-1:0] dp,
                                            output bit bad);
    logic [63:0] span;
    int          i;
    span = 64'd1;
    bad  = (ar < 2);
    if (!bad) begin
      for (i = 0; i < int'(dp); i++) begin
        span = span * ar;
        if (span > (64'd1 << LEAF_W)) begin
          bad = 1'b1;
          break;
        end
      end
    end
    return span;
  endfunction

  function automatic res_t mk_res(input logic [63:0] addr, input int lvl, input int slot,
                                  input bit last, input bit err);
    res_t r;
    r.address = addr[ADDR_W-1:0];
    r.level   = LEVEL_W'(lvl);
    r.slot    = SLOT_W'(slot);
    r.last    = last;
    r.error   = err;
    return r;
  endfunction

  task automatic post_res(input res_t r);
    addr_q = {addr_q, r};
  endtask

  task automatic walk_path(input req_t r);
    logic [63:0] span, n, a, bucket;
    logic [63:0] node[16];
    bit          bad;
    int          dp, zs, total, count, l, s;
    dp = int'(shadow.depth);
    zs = int'(shadow.slots);
    if (zs == 0) zs = 1;
    if (zs > 4) zs = 4;
    span = leaf_span(shadow.arity, shadow.depth, bad);
    if (!bad && r.leaf >= span) bad = 1'b1;
    if (bad) begin
      post_res(mk_res(64'd0, 0, 0, 1'b1, 1'b1));
      return;
    end
    n = r.leaf + span;
    for (l = dp; l >= 0; l--) begin
      node[l] = n - 64'd1;
      n = n / shadow.arity;
    end
    total = r.cmd ? dp + 1 : (dp + 1) * zs;
    count = 0;
    for (l = 0; l <= dp; l++) begin
      if (r.cmd) begin
        a = shadow.header_base + node[l] * shadow.block_bytes;
        count++;
        post_res(mk_res(a, l, 0, count == total, 1'b0));
      end else begin
        bucket = shadow.tree_base + node[l] * shadow.bucket_bytes;
        for (s = 0; s < zs; s++) begin
          a = bucket + s * shadow.block_bytes;
          count++;
          post_res(mk_res(a, l, s, count == total, 1'b0));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      walk_path(in_req);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (leaf_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
      start  <= 1'b1;
      in_req <= leaf_q.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n && out_valid) begin
      if (addr_q.size() == 0) begin
        $error("unexpected result: address %0h level %0d", out_res.address, out_res.level);
        errors++;
      end else begin
        want = addr_q.pop_front();
        check_field("address", want.address, out_res.address);
        check_field("level", want.level, out_res.level);
        check_field("slot", want.slot, out_res.slot);
        check_field("last", want.last, out_res.last);
        check_field("error", want.error, out_res.error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[ADDR_W-1:0];
    case (idx)
      CFG_TREE_BASE:   shadow.tree_base    = val[ADDR_W-1:0];
      CFG_BUCKET:      shadow.bucket_bytes = val[BUCKET_W-1:0];
      CFG_BLOCK:       shadow.block_bytes  = val[BLOCK_W-1:0];
      CFG_SLOTS:       shadow.slots        = val[SLOTS_W-1:0];
      CFG_ARITY:       shadow.arity        = val[ARITY_W-1:0];
      CFG_DEPTH:       shadow.depth        = val[LEVEL_W-1:0];
      CFG_HEADER_BASE: shadow.header_base  = val[ADDR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(input bit cmd, input logic [LEAF_W-1:0] leaf);
    req_t r;
    r.cmd  = cmd;
    r.leaf = leaf;
    leaf_q = {leaf_q, r};
  endtask

  task automatic drain();
    do @(negedge clk);
    while (leaf_q.size() != 0 || start || addr_q.size() != 0 || busy);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [63:0] rand40(input bit junk);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return junk ? v : {24'd0, v[ADDR_W-1:0]};
  endfunction

  task automatic random_setup();
    logic [63:0] span;
    bit          bad;
    int          ar, dp, pick;
    pick = $urandom_range(99, 0);
    if (pick < 75) ar = $urandom_range(16, 2);
    else if (pick < 88) ar = $urandom_range(31, 17);
    else ar = $urandom_range(1, 0);
    dp = $urandom_range(15, 0);
    if ($urandom_range(99, 0) < 85) begin
      span = leaf_span(ARITY_W'(ar), LEVEL_W'(dp), bad);
      while (bad && dp > 0 && ar >= 2) begin
        dp--;
        span = leaf_span(ARITY_W'(ar), LEVEL_W'(dp), bad);
      end
    end
    write_reg(CFG_TREE_BASE, rand40(1'b0));
    write_reg(CFG_BUCKET, ($urandom_range(9, 0) == 0) ? rand40(1'b1)
                                                     : 64'($urandom_range(65536, 1)));
    write_reg(CFG_BLOCK, ($urandom_range(9, 0) == 0) ? rand40(1'b1)
                                                    : 64'($urandom_range(4096, 1)));
    write_reg(CFG_SLOTS, 64'($urandom_range(7, 0)));
    write_reg(CFG_ARITY, 64'(ar));
    write_reg(CFG_DEPTH, 64'(dp));
    write_reg(CFG_HEADER_BASE, rand40(1'b0));
  endtask

  task automatic random_items(input int count);
    logic [63:0]       span;
    bit                bad;
    int                k, pick;
    logic [LEAF_W-1:0] lf;
    span = leaf_span(shadow.arity, shadow.depth, bad);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 10) lf = LEAF_W'(span - 64'd1);
      else if (pick < 15) lf = '0;
      else if (pick < 82) lf = LEAF_W'({32'd0, $urandom} % span);
      else lf = LEAF_W'($urandom);
      queue_req(1'($urandom_range(1, 0)), lf);
    end
  endtask

  initial begin : stimulus
    int p;
    int gaps[4];
    gaps = '{0, 77, 0, 13};
    shadow.tree_base    = RST_TREE_BASE;
    shadow.bucket_bytes = RST_BUCKET;
    shadow.block_bytes  = RST_BLOCK;
    shadow.slots        = RST_SLOTS;
    shadow.arity        = RST_ARITY;
    shadow.depth        = RST_DEPTH;
    shadow.header_base  = RST_HEADER_BASE;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: binary tree, depth fifteen, four slots
    queue_req(1'b0, '0);
    queue_req(1'b1, LEAF_W'(32767));
    queue_req(1'b0, LEAF_W'(32767));
    queue_req(1'b1, LEAF_W'(32768));
    drain();

    // widest index space with both bases at their top, addresses wrap
    write_reg(CFG_ARITY, 64'd4);
    write_reg(CFG_DEPTH, 64'd15);
    write_reg(CFG_TREE_BASE, 64'hFF_FFFF_FFFF);
    write_reg(CFG_BUCKET, 64'd65536);
    write_reg(CFG_BLOCK, 64'd4096);
    write_reg(CFG_HEADER_BASE, 64'hFF_FFFF_FFFF);
    write_reg(CFG_SLOTS, 64'd7);
    queue_req(1'b0, '1);
    queue_req(1'b1, '1);
    queue_req(1'b1, '0);
    drain();

    // root only, zero slot count, unit strides
    write_reg(CFG_DEPTH, 64'd0);
    write_reg(CFG_SLOTS, 64'd0);
    write_reg(CFG_TREE_BASE, 64'd0);
    write_reg(CFG_BUCKET, 64'd1);
    write_reg(CFG_BLOCK, 64'd1);
    write_reg(CFG_HEADER_BASE, 64'd0);
    queue_req(1'b0, '0);
    queue_req(1'b1, '0);
    queue_req(1'b0, LEAF_W'(1));
    drain();

    // degenerate arity
    write_reg(CFG_DEPTH, 64'd3);
    write_reg(CFG_ARITY, 64'd0);
    queue_req(1'b0, '0);
    drain();
    write_reg(CFG_ARITY, 64'd1);
    queue_req(1'b1, '0);
    drain();

    // arity above sixteen, unused index must leave the registers alone
    write_reg(CFG_ARITY, 64'd17);
    write_reg(CFG_DEPTH, 64'd7);
    write_reg(CFG_SLOTS, 64'd2);
    write_reg(CFG_UNUSED, rand40(1'b1));
    queue_req(1'b0, LEAF_W'(410338672));
    queue_req(1'b1, LEAF_W'(5));
    drain();
    write_reg(CFG_ARITY, 64'd31);
    write_reg(CFG_DEPTH, 64'd6);
    queue_req(1'b1, LEAF_W'(887503680));
    queue_req(1'b0, LEAF_W'(887503681));
    drain();

    // index overflow, then the deepest legal hex tree with zero strides
    write_reg(CFG_ARITY, 64'd16);
    write_reg(CFG_DEPTH, 64'd8);
    queue_req(1'b0, '0);
    drain();
    write_reg(CFG_DEPTH, 64'd7);
    write_reg(CFG_SLOTS, 64'd3);
    write_reg(CFG_BUCKET, 64'hFF_FFFE_0000);
    write_reg(CFG_BLOCK, 64'hFF_FFFF_E000);
    queue_req(1'b1, LEAF_W'(268435455));
    queue_req(1'b0, LEAF_W'(3));
    drain();

    for (p = 0; p < 8; p++) begin
      random_setup();
      gap_pct = gaps[p % 4];
      random_items(14);
      drain();
    end

    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && addr_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
